// File: hw/rtl/ntib_pkg.sv
// ----------------------------------------------------------------------------
// ntib_pkg
// Shared constants and types for the modular butterfly pipeline.
// ----------------------------------------------------------------------------
package ntib_pkg;

  // default residue width
  localparam int DATA_WIDTH_DEF = 60;

  // configuration port geometry
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 2;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MODULUS        = 2'd0,
    CFG_BARRETT_FACTOR = 2'd1,
    CFG_BARRETT_SHIFT  = 2'd2,
    CFG_FORWARD_MODE   = 2'd3
  } cfg_idx_t;

  // pipeline advance and the valid bit entering a section
  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

endpackage

// File: hw/rtl/ntt_intt_modular_butterfly.sv
// ----------------------------------------------------------------------------
// ntt_intt_modular_butterfly
// Datapath: two chains of DATA_WIDTH modular step stages: operand reduction,
// then the bit-per-stage modular product.
// Throughput: one item per cycle while the skid entry is free; the input
// keeps flowing while one result waits at the output. Reset clears all
// valid bits, sets q = 3, forward mode.
// ----------------------------------------------------------------------------
module ntt_intt_modular_butterfly
  import ntib_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [CFG_ADDR_W-1:0]            cfg_addr,
  input  logic [CFG_DATA_W-1:0]            cfg_wdata,
  // input items
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // fields from bit 0: first_residue, second_residue, twiddle, zero fill
  input  logic [((3*DATA_WIDTH+7)/8)*8-1:0] in_tdata,
  // result items
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // fields from bit 0: upper_result, lower_result, zero fill
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0] out_tdata
);

  localparam int W     = DATA_WIDTH;
  localparam int OUT_W = ((2 * W + 7) / 8) * 8;

  // modular helpers, operands below q
  function automatic logic [W-1:0] mod_add(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] m);
    logic [W:0]   s;
    logic [W+1:0] d;
    s = {1'b0, x} + {1'b0, y};
    d = {1'b0, s} - {2'b00, m};
    return d[W+1] ? s[W-1:0] : d[W-1:0];
  endfunction

  function automatic logic [W-1:0] mod_sub(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] m);
    logic [W:0] d;
    d = {1'b0, x} - {1'b0, y};
    return d[W-1:0] + (d[W] ? m : '0);
  endfunction

  function automatic logic [W-1:0] halve(input logic [W-1:0] x, input logic [W-1:0] hq);
    return (x >> 1) + (x[0] ? hq : '0);
  endfunction

  logic [W-1:0]     q_r;
  logic             fwd_r;
  logic             q_small;
  logic [W:0]       q_inc;
  logic [W-1:0]     half_q;
  logic             pipe_en;
  pipe_ctl_t        in_ctl;
  pipe_ctl_t        prep_ctl;
  pipe_ctl_t        fin_ctl;
  logic [W-1:0]     a_red;
  logic [W-1:0]     b_red;
  logic [W-1:0]     w_red;
  logic             red_valid;
  logic [W-1:0]     mx_r;
  logic [W-1:0]     my_r;
  logic [2*W-1:0]   side_r;
  logic             prep_vld_r;
  logic [W-1:0]     prod;
  logic [2*W-1:0]   prod_side;
  logic             prod_valid;
  logic [W-1:0]     fin_a;
  logic [W-1:0]     fin_sum;
  logic [W-1:0]     up_nxt;
  logic [W-1:0]     lo_nxt;
  logic [W-1:0]     up_r;
  logic [W-1:0]     lo_r;
  logic             fin_vld_r;
  logic             buf_ready;

  // configuration registers; barrett constants hold no state here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r   <= W'(3);
      fwd_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr)) inside
        CFG_MODULUS: begin
          q_r <= cfg_wdata[W-1:0];
        end
        CFG_FORWARD_MODE: begin
          fwd_r <= cfg_wdata[0];
        end
        CFG_BARRETT_FACTOR, CFG_BARRETT_SHIFT: begin
        end
      endcase
    end
  end

  assign q_small = (q_r < W'(3));
  assign q_inc   = {1'b0, q_r} + {{W{1'b0}}, 1'b1};
  assign half_q  = q_inc[W:1];

  // whole pipeline advances while the skid entry is free
  assign pipe_en   = buf_ready;
  assign in_tready = pipe_en;

  assign in_ctl   = '{en: pipe_en, valid: in_tvalid};
  assign prep_ctl = '{en: pipe_en, valid: prep_vld_r};
  assign fin_ctl  = '{en: pipe_en, valid: fin_vld_r};

  // operand reduction
  ntib_reduce #(
    .W(W)
  ) u_reduce (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (in_ctl),
    .q         (q_r),
    .a_raw     (in_tdata[W-1:0]),
    .b_raw     (in_tdata[2*W-1:W]),
    .w_raw     (in_tdata[3*W-1:2*W]),
    .a_red     (a_red),
    .b_red     (b_red),
    .w_red     (w_red),
    .red_valid (red_valid)
  );

  // multiplier operands by mode; sideband carries a and a+b
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_vld_r <= 1'b0;
    end else if (pipe_en) begin
      prep_vld_r <= red_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      mx_r   <= fwd_r ? w_red : mod_sub(a_red, b_red, q_r);
      my_r   <= fwd_r ? b_red : w_red;
      side_r <= {mod_add(a_red, b_red, q_r), a_red};
    end
  end

  // modular product
  ntib_mulmod #(
    .W      (W),
    .SIDE_W (2 * W)
  ) u_mulmod (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (prep_ctl),
    .q          (q_r),
    .x          (mx_r),
    .y          (my_r),
    .side_in    (side_r),
    .prod       (prod),
    .side_out   (prod_side),
    .prod_valid (prod_valid)
  );

  // final butterfly combine
  assign fin_a   = prod_side[W-1:0];
  assign fin_sum = prod_side[2*W-1:W];

  always_comb begin
    if (q_small) begin
      up_nxt = '0;
      lo_nxt = '0;
    end else if (fwd_r) begin
      up_nxt = mod_add(fin_a, prod, q_r);
      lo_nxt = mod_sub(fin_a, prod, q_r);
    end else begin
      up_nxt = halve(fin_sum, half_q);
      lo_nxt = halve(prod, half_q);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else if (pipe_en) begin
      fin_vld_r <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      up_r <= up_nxt;
      lo_r <= lo_nxt;
    end
  end

  // output buffer
  ntib_out_buf #(
    .DW(OUT_W)
  ) u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (fin_ctl),
    .push_data (OUT_W'({lo_r, up_r})),
    .buf_ready (buf_ready),
    .out_valid (out_tvalid),
    .out_data  (out_tdata),
    .out_ready (out_tready)
  );

  // input only stalls behind a waiting result
  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result at the output");

  // degenerate modulus gives zero results
  a_small_q_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $past(pipe_en && prod_valid && q_small) |-> (up_r == '0 && lo_r == '0))
    else $error("nonzero result for modulus below three");

endmodule

// File: hw/rtl/ntib_modstep.sv
// ----------------------------------------------------------------------------
// ntib_modstep
// One double-and-add step modulo q: r_next = (2*r + (addend_en ? x : 0)) mod q,
// for r and x both below q.
// ----------------------------------------------------------------------------
module ntib_modstep
  import ntib_pkg::*;
#(
  parameter int W = DATA_WIDTH_DEF
) (
  input  logic [W-1:0] r,
  input  logic [W-1:0] x,
  input  logic         addend_en,
  input  logic [W-1:0] q,
  output logic [W-1:0] r_next
);

  logic [W+1:0] sum;
  logic [W+2:0] diff1;
  logic [W+2:0] diff2;

  // sum stays below 3q, so at most 2q comes off
  assign sum   = {1'b0, r, 1'b0} + {2'b00, x & {W{addend_en}}};
  assign diff1 = {1'b0, sum} - {3'b000, q};
  assign diff2 = {1'b0, sum} - {2'b00, q, 1'b0};

  // pick the largest subtraction that does not borrow
  always_comb begin
    if (!diff2[W+2]) begin
      r_next = diff2[W-1:0];
    end else if (!diff1[W+2]) begin
      r_next = diff1[W-1:0];
    end else begin
      r_next = sum[W-1:0];
    end
  end

endmodule

// File: hw/rtl/ntib_reduce.sv
// ----------------------------------------------------------------------------
// ntib_reduce
// Three-lane pipelined reduction of raw operands modulo q, one bit of each
// operand per stage, most significant bit first.
// ----------------------------------------------------------------------------
module ntib_reduce
  import ntib_pkg::*;
#(
  parameter int W = DATA_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  pipe_ctl_t    ctl,
  input  logic [W-1:0] q,
  input  logic [W-1:0] a_raw,
  input  logic [W-1:0] b_raw,
  input  logic [W-1:0] w_raw,
  output logic [W-1:0] a_red,
  output logic [W-1:0] b_red,
  output logic [W-1:0] w_red,
  output logic         red_valid
);

  localparam int LANES = 3;

  logic [W-1:0] src_in   [LANES];
  logic [W-1:0] rem_prev [W][LANES];
  logic [W-1:0] src_prev [W][LANES];
  logic [W-1:0] rem_nxt  [W][LANES];
  logic [W-1:0] rem_r    [W][LANES];
  logic [W-1:0] src_r    [W][LANES];
  logic [W-1:0] vld_r;

  assign src_in[0] = a_raw;
  assign src_in[1] = b_raw;
  assign src_in[2] = w_raw;

  // per stage and lane: shift in the next source bit
  for (genvar k = 0; k < W; k++) begin : g_stage
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      if (k == 0) begin : g_first
        assign rem_prev[k][l] = '0;
        assign src_prev[k][l] = src_in[l];
      end else begin : g_next
        assign rem_prev[k][l] = rem_r[k-1][l];
        assign src_prev[k][l] = src_r[k-1][l];
      end

      ntib_modstep #(
        .W(W)
      ) u_step (
        .r         (rem_prev[k][l]),
        .x         (W'(1)),
        .addend_en (src_prev[k][l][W-1]),
        .q         (q),
        .r_next    (rem_nxt[k][l])
      );
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.en) begin
      vld_r <= {vld_r[W-2:0], ctl.valid};
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int k = 0; k < W; k++) begin
        for (int l = 0; l < LANES; l++) begin
          rem_r[k][l] <= rem_nxt[k][l];
          src_r[k][l] <= src_prev[k][l] << 1;
        end
      end
    end
  end

  assign a_red     = rem_r[W-1][0];
  assign b_red     = rem_r[W-1][1];
  assign w_red     = rem_r[W-1][2];
  assign red_valid = vld_r[W-1];

endmodule

// File: hw/rtl/ntib_mulmod.sv
// ----------------------------------------------------------------------------
// ntib_mulmod
// Pipelined interleaved modular multiplier: x*y mod q, one bit of y per
// stage, with a sideband word carried alongside each item.
// ----------------------------------------------------------------------------
module ntib_mulmod
  import ntib_pkg::*;
#(
  parameter int W      = DATA_WIDTH_DEF,
  parameter int SIDE_W = 2 * DATA_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pipe_ctl_t         ctl,
  input  logic [W-1:0]      q,
  input  logic [W-1:0]      x,
  input  logic [W-1:0]      y,
  input  logic [SIDE_W-1:0] side_in,
  output logic [W-1:0]      prod,
  output logic [SIDE_W-1:0] side_out,
  output logic              prod_valid
);

  logic [W-1:0]      rem_prev  [W];
  logic [W-1:0]      x_prev    [W];
  logic [W-1:0]      y_prev    [W];
  logic [SIDE_W-1:0] side_prev [W];
  logic [W-1:0]      rem_nxt   [W];
  logic [W-1:0]      rem_r     [W];
  logic [W-1:0]      x_r       [W];
  logic [W-1:0]      y_r       [W];
  logic [SIDE_W-1:0] side_r    [W];
  logic [W-1:0]      vld_r;

  // each stage doubles the partial product and adds x for one bit of y
  for (genvar k = 0; k < W; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign rem_prev[k]  = '0;
      assign x_prev[k]    = x;
      assign y_prev[k]    = y;
      assign side_prev[k] = side_in;
    end else begin : g_next
      assign rem_prev[k]  = rem_r[k-1];
      assign x_prev[k]    = x_r[k-1];
      assign y_prev[k]    = y_r[k-1];
      assign side_prev[k] = side_r[k-1];
    end

    ntib_modstep #(
      .W(W)
    ) u_step (
      .r         (rem_prev[k]),
      .x         (x_prev[k]),
      .addend_en (y_prev[k][W-1]),
      .q         (q),
      .r_next    (rem_nxt[k])
    );
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.en) begin
      vld_r <= {vld_r[W-2:0], ctl.valid};
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int k = 0; k < W; k++) begin
        rem_r[k]  <= rem_nxt[k];
        x_r[k]    <= x_prev[k];
        y_r[k]    <= y_prev[k] << 1;
        side_r[k] <= side_prev[k];
      end
    end
  end

  assign prod       = rem_r[W-1];
  assign side_out   = side_r[W-1];
  assign prod_valid = vld_r[W-1];

endmodule

// File: hw/rtl/ntib_out_buf.sv
// ----------------------------------------------------------------------------
// ntib_out_buf
// Two-entry output buffer: an output register plus a skid register, so the
// pipeline keeps moving while one result waits at the port.
// ----------------------------------------------------------------------------
module ntib_out_buf
  import ntib_pkg::*;
#(
  parameter int DW = 2 * DATA_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  pipe_ctl_t     ctl,
  input  logic [DW-1:0] push_data,
  output logic          buf_ready,
  output logic          out_valid,
  output logic [DW-1:0] out_data,
  input  logic          out_ready
);

  logic          out_vld_r;
  logic          skid_vld_r;
  logic [DW-1:0] out_data_r;
  logic [DW-1:0] skid_data_r;
  logic          push;
  logic          pop;

  assign push = ctl.en && ctl.valid;
  assign pop  = out_vld_r && out_ready;

  // occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (pop) begin
        skid_vld_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_vld_r || pop) begin
        out_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (pop) begin
      out_vld_r <= 1'b0;
    end
  end

  // data
  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (!out_vld_r || pop) begin
        out_data_r <= push_data;
      end else begin
        skid_data_r <= push_data;
      end
    end
  end

  assign buf_ready = !skid_vld_r;
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // the skid entry only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry valid with empty output register");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(out_vld_r && !out_ready && ctl.en && ctl.valid))
    else $error("skid entry filled without a stalled push");

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the modular NTT/INTT butterfly. Random bursts of
// operand triples go in under a series of modulus and mode settings, and
// every result item is checked against a predictor of the butterfly math
// kept alongside the register settings.
// ----------------------------------------------------------------------------
module tb;
  import ntib_pkg::*;

  localparam int DW          = DATA_WIDTH_DEF;
  localparam int IN_W        = ((3*DW+7)/8)*8;
  localparam int OUT_W       = ((2*DW+7)/8)*8;
  localparam int LATENCY     = 2*DW + 2;
  localparam int ITEM_TARGET = 1950;

  typedef bit [DW-1:0] residue_t;
  localparam residue_t RES_MAX = '1;

  // expected butterfly results in acceptance order, with a copy of the registers
  class butterfly_scoreboard;
    residue_t      mod_q;
    bit [63:0]     barrett_factor;
    bit [6:0]      barrett_shift;
    bit            fwd;
    bit [2*DW-1:0] expected_pairs[$];
    int            mismatches;
    int            results_seen;

    function new();
      mod_q          = 3;
      barrett_factor = '0;
      barrett_shift  = '0;
      fwd            = 1'b1;
      mismatches     = 0;
      results_seen   = 0;
    endfunction

    // bits above a register's width are dropped
    function void write_reg(cfg_idx_t idx, bit [63:0] value);
      case (idx)
        CFG_MODULUS:        mod_q = value[DW-1:0];
        CFG_BARRETT_FACTOR: barrett_factor = value;
        CFG_BARRETT_SHIFT:  barrett_shift = value[6:0];
        CFG_FORWARD_MODE:   fwd = value[0];
        default: ;
      endcase
    endfunction

    function residue_t mod_add(residue_t x, residue_t y);
      bit [DW:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, mod_q}) s = s - {1'b0, mod_q};
      return s[DW-1:0];
    endfunction

    function residue_t mod_sub(residue_t x, residue_t y);
      bit [DW:0] d;
      if (x >= y) return x - y;
      d = {1'b0, x} + {1'b0, mod_q} - {1'b0, y};
      return d[DW-1:0];
    endfunction

    // exact product, reduced from the full double-width value
    function residue_t mod_mul(residue_t x, residue_t y);
      bit [2*DW-1:0] p;
      p = {{DW{1'b0}}, x} * {{DW{1'b0}}, y};
      p = p % {{DW{1'b0}}, mod_q};
      return p[DW-1:0];
    endfunction

    // x/2, adding (q+1)/2 for odd x
    function residue_t halve(residue_t x);
      bit [DW:0] h;
      h = {1'b0, x} >> 1;
      if (x[0]) h = h + (({1'b0, mod_q} + 1'b1) >> 1);
      return h[DW-1:0];
    endfunction

    // returns {lower_result, upper_result}
    function bit [2*DW-1:0] predict_butterfly(residue_t a_in, residue_t b_in, residue_t w_in);
      residue_t a, b, w, t, up, lo;
      if (mod_q < 3) return '0;
      a = a_in % mod_q;
      b = b_in % mod_q;
      w = w_in % mod_q;
      if (fwd) begin
        t  = mod_mul(b, w);
        up = mod_add(a, t);
        lo = mod_sub(a, t);
      end else begin
        up = halve(mod_add(a, b));
        lo = halve(mod_mul(mod_sub(a, b), w));
      end
      return {lo, up};
    endfunction

    function void note_item(residue_t a, residue_t b, residue_t w);
      expected_pairs.push_back(predict_butterfly(a, b, w));
    endfunction

    function void flag(string what, logic [DW-1:0] want, logic [DW-1:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d %s: expected %h, got %h", results_seen, what, want, got);
    endfunction

    function void check_result(logic [2*DW-1:0] got);
      bit [2*DW-1:0] want;
      results_seen++;
      if (expected_pairs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with nothing expected: %h", results_seen, got);
        return;
      end
      want = expected_pairs.pop_front();
      if (got[DW-1:0] !== want[DW-1:0])
        flag("upper_result", want[DW-1:0], got[DW-1:0]);
      if (got[2*DW-1:DW] !== want[2*DW-1:DW])
        flag("lower_result", want[2*DW-1:DW], got[2*DW-1:DW]);
    endfunction

    function int pending();
      return expected_pairs.size();
    endfunction

    function void close();
      if (expected_pairs.size() != 0) begin
        mismatches += expected_pairs.size();
        $display("%0d expected results never arrived", expected_pairs.size());
      end
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = CFG_MODULUS;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  // fields from bit 0: first_residue, second_residue, twiddle, zero fill
  logic [IN_W-1:0]       in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // fields from bit 0: upper_result, lower_result, zero fill
  logic [OUT_W-1:0]      out_tdata;

  butterfly_scoreboard sb = new();

  int burst_left = 0;
  int n_items    = 0;

  ntt_intt_modular_butterfly #(
    .DATA_WIDTH(DW)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("timeout: results still outstanding: %0d", sb.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result sink: stretches of full rate, random stalls, sparse and periodic ready
  initial begin
    int mode, len, tick;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(16, 160);
      repeat (len) begin
        @(posedge clk);
        tick++;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= $urandom_range(0, 1);
          2: out_tready <= ($urandom_range(0, 4) == 0);
          default: out_tready <= (tick % 3 != 0);
        endcase
      end
    end
  end

  // result check
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata[2*DW-1:0]);
  end

  function automatic residue_t rand_residue();
    return residue_t'({$urandom, $urandom});
  endfunction

  // mostly reduced operands, some edges, some unreduced values
  function automatic residue_t pick_operand(residue_t q);
    residue_t r;
    r = rand_residue();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return (q == 0) ? '0 : q - 1'b1;
      2: return residue_t'(1);
      3: return (r == RES_MAX) ? r - 1'b1 : r;
      default: return (q == 0) ? r : r % q;
    endcase
  endfunction

  function automatic residue_t pick_modulus();
    residue_t m;
    case ($urandom_range(0, 11))
      0: m = residue_t'($urandom_range(1, 31) * 2 + 1);
      1: m = RES_MAX;
      2: m = residue_t'($urandom_range(0, 2));
      3: m = rand_residue() & ~residue_t'(1);
      default: begin
        m = (rand_residue() >> $urandom_range(0, 56)) | residue_t'(1);
        if (m < 3) m = residue_t'(3);
      end
    endcase
    return m;
  endfunction

  task automatic cfg_write(input cfg_idx_t idx, input bit [63:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic set_config(input bit [63:0] q_val, input bit [63:0] factor,
                            input bit [63:0] half_shift, input bit [63:0] fwd_val);
    cfg_write(CFG_MODULUS, q_val);
    cfg_write(CFG_BARRETT_FACTOR, factor);
    cfg_write(CFG_BARRETT_SHIFT, half_shift);
    cfg_write(CFG_FORWARD_MODE, fwd_val);
    cfg_we <= 1'b0;
  endtask

  // one item; bursts of random length with random gaps between them
  task automatic send_item(input residue_t a, input residue_t b, input residue_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'({w, b, a});
    do @(posedge clk); while (!in_tready);
    burst_left--;
    sb.note_item(a, b, w);
    n_items++;
  endtask

  // hold the input until every expected result has come back
  task automatic drain();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // stimulus
  initial begin
    residue_t  q;
    bit [63:0] r64;
    int        count, n_settings, n_fwd, n_inv, n_degen;
    n_settings = 0;
    n_fwd      = 0;
    n_inv      = 0;
    n_degen    = 0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: q = 3, forward; large operands need reduction
    send_item('0, '0, '0);
    send_item(RES_MAX - 1'b1, RES_MAX - 1'b1, RES_MAX - 1'b1);
    send_item(residue_t'(5), residue_t'(4), residue_t'(7));
    send_item(residue_t'(2), residue_t'(2), residue_t'(2));
    drain();

    // widest odd modulus, forward, barrett registers at their extremes
    set_config(64'(RES_MAX), '1, 64'd64, 64'd1);
    q = sb.mod_q;
    send_item('0, '0, '0);
    send_item(q - 1'b1, q - 1'b1, q - 1'b1);
    send_item('0, q - 1'b1, residue_t'(1));
    send_item(q - 1'b1, residue_t'(1), q - 1'b1);
    send_item(residue_t'(1), '0, q - 2'd2);
    send_item('0, residue_t'(1), '0);
    drain();

    // same modulus, inverse with halving of odd values
    set_config(64'(RES_MAX), '0, '0, '0);
    send_item('0, '0, '0);
    send_item(q - 1'b1, q - 1'b1, q - 1'b1);
    send_item(residue_t'(1), '0, residue_t'(1));
    send_item('0, residue_t'(1), q - 1'b1);
    send_item(q - 1'b1, residue_t'(1), residue_t'(2));
    send_item(q - 2'd2, q - 1'b1, q - 1'b1);
    drain();

    // modulus below three, with junk above the modulus, shift and mode widths
    set_config({4'hF, 60'd2}, 64'h0123_4567_89AB_CDEF, 64'hFFFF_FFFF_FFFF_FF80, '1 << 1);
    send_item(residue_t'(1), residue_t'(1), residue_t'(1));
    send_item(RES_MAX - 1'b1, rand_residue() >> 1, RES_MAX - 1'b1);
    send_item('0, '0, '0);
    drain();

    // even modulus in inverse mode
    set_config(64'd1_000_000_000_006, '0, 64'd40, '0);
    q = sb.mod_q;
    send_item(q + 3'd5, q - 2'd2, residue_t'(3));
    send_item(q - 1'b1, q - 2'd2, residue_t'(3));
    send_item(residue_t'(1), '0, q - 1'b1);
    send_item(RES_MAX - 1'b1, residue_t'(7), RES_MAX - 1'b1);
    drain();

    // random settings, each followed by a full drain
    while (n_items < ITEM_TARGET) begin
      r64 = {$urandom, $urandom};
      set_config({r64[63:60], pick_modulus()}, {$urandom, $urandom},
                 {r64[63:7], 7'($urandom_range(0, 64))}, {r64[63:1], 1'($urandom_range(0, 1))});
      q = sb.mod_q;
      n_settings++;
      if (q < 3) n_degen++;
      else if (sb.fwd) n_fwd++;
      else n_inv++;
      count = $urandom_range(40, 200);
      repeat (count) send_item(pick_operand(q), pick_operand(q), pick_operand(q));
      drain();
    end

    repeat (LATENCY + 16) @(posedge clk);
    sb.close();

    $display("%0d butterflies, %0d results checked, %0d random settings",
             n_items, sb.results_seen, n_settings);
    $display("random settings: %0d forward, %0d inverse, %0d with modulus below three",
             n_fwd, n_inv, n_degen);
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
